// ----- rtl/atap_pkg.sv -----
// Shared types, codes and constants of the ATA PIO sector transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none
package atap_pkg;

    // Sector geometry
    localparam int WORDS_PER_SECTOR = 256;
    localparam int WIDX_W = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
    localparam logic [WIDX_W-1:0] WIDX_LAST = WIDX_W'(WORDS_PER_SECTOR - 1);

    // Field widths
    localparam int LBA_W      = 48;
    localparam int CNT_W      = 16;
    localparam int CAP28_W    = 32;
    localparam int POLL_W     = 20;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int RUN_IDX_W  = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SHORT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LONG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 2'd3;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 20'd100000;

    // Operation codes of an input item
    localparam logic [2:0] OP_READ28  = 3'd0;
    localparam logic [2:0] OP_WRITE28 = 3'd1;
    localparam logic [2:0] OP_READ48  = 3'd2;
    localparam logic [2:0] OP_WRITE48 = 3'd3;
    localparam logic [2:0] OP_STATUS  = 3'd4;
    localparam logic [2:0] OP_DATA    = 3'd5;

    // Result kinds
    localparam logic [1:0] K_REG    = 2'd0;
    localparam logic [1:0] K_STATUS = 2'd1;
    localparam logic [1:0] K_WORD   = 2'd2;
    localparam logic [1:0] K_DONE   = 2'd3;

    // Completion codes
    localparam logic [2:0] C_OK       = 3'd0;
    localparam logic [2:0] C_BADCOUNT = 3'd1;
    localparam logic [2:0] C_RANGE    = 3'd2;
    localparam logic [2:0] C_ERROR    = 3'd3;
    localparam logic [2:0] C_FAULT    = 3'd4;
    localparam logic [2:0] C_TIMEOUT  = 3'd5;

    // Task file register offsets
    localparam logic [2:0] REG_DATA  = 3'd0;
    localparam logic [2:0] REG_COUNT = 3'd2;
    localparam logic [2:0] REG_LBA0  = 3'd3;
    localparam logic [2:0] REG_LBA1  = 3'd4;
    localparam logic [2:0] REG_LBA2  = 3'd5;
    localparam logic [2:0] REG_DRIVE = 3'd6;
    localparam logic [2:0] REG_CMD   = 3'd7;

    // Status bit positions
    localparam int ST_ERR_BIT = 0;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_DF_BIT  = 5;
    localparam int ST_BSY_BIT = 7;

    // Command bytes
    localparam logic [7:0] CMD_RD28  = 8'h20;
    localparam logic [7:0] CMD_WR28  = 8'h30;
    localparam logic [7:0] CMD_RD48  = 8'h24;
    localparam logic [7:0] CMD_WR48  = 8'h34;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;
    localparam logic [7:0] DRV_BASE  = 8'hE0;
    localparam logic [CNT_W-1:0] MAX_COUNT28 = 16'd255;

    typedef struct packed {
        logic [2:0]       operation;
        logic [LBA_W-1:0] start_address;
        logic [CNT_W-1:0] sector_total;
        logic [7:0]       status_byte;
        logic [15:0]      data_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  register_offset;
        logic [15:0] value;
        logic [2:0]  completion_code;
        logic        last_of_run;
    } t_out_item;

    typedef struct packed {
        logic [CAP28_W-1:0] total_sectors_short;
        logic [LBA_W-1:0]   total_sectors_long;
        logic               slave_select;
        logic [POLL_W-1:0]  poll_limit;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DRQ,
        PH_DATA,
        PH_BSY
    } t_phase;

    // Shape of the result run one item causes
    typedef enum logic [2:0] {
        RUN_NONE,
        RUN_DONE,
        RUN_STATUS,
        RUN_TASK28,
        RUN_TASK48,
        RUN_WORD
    } t_run;

    // What follows a data word at the end of a sector
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_STATUS,
        TAIL_FLUSH,
        TAIL_DONE
    } t_tail;

    typedef struct packed {
        t_run             run;
        t_tail            tail;
        logic [2:0]       code;
        logic             writing;
        logic [7:0]       drive;
        logic [7:0]       command;
        logic [LBA_W-1:0] lba;
        logic [CNT_W-1:0] count;
        logic [15:0]      word;
    } t_run_desc;

endpackage
`default_nettype wire

// ----- rtl/atap_cfg.sv -----
// Configuration register file of the ATA PIO sector transfer sequencer.
`timescale 1ns / 1ps
`default_nettype none
module atap_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [atap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [atap_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output atap_pkg::t_cfg                          o_cfg
);

    atap_pkg::t_cfg r_cfg;

    // Write one register per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.total_sectors_short <= '0;
            r_cfg.total_sectors_long  <= '0;
            r_cfg.slave_select        <= 1'b0;
            r_cfg.poll_limit          <= atap_pkg::POLL_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                atap_pkg::CFG_TOTAL_SHORT: begin
                    r_cfg.total_sectors_short <= i_cfg_data[atap_pkg::CAP28_W-1:0];
                end
                atap_pkg::CFG_TOTAL_LONG: begin
                    r_cfg.total_sectors_long <= i_cfg_data[atap_pkg::LBA_W-1:0];
                end
                atap_pkg::CFG_SLAVE: begin
                    r_cfg.slave_select <= i_cfg_data[0];
                end
                atap_pkg::CFG_POLL_LIMIT: begin
                    r_cfg.poll_limit <= i_cfg_data[atap_pkg::POLL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- rtl/atap_engine.sv -----
// Input register and command state machine: turns each item into a result run.
`timescale 1ns / 1ps
`default_nettype none
module atap_engine (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire atap_pkg::t_cfg      i_cfg,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire atap_pkg::t_in_item  i_in,
    input  wire logic                i_run_free,
    output logic                     o_run_load,
    output atap_pkg::t_run_desc      o_run
);

    logic                             r_in_valid;
    atap_pkg::t_in_item               r_in;
    atap_pkg::t_phase                 r_phase, n_phase;
    logic                             r_writing, n_writing;
    logic [atap_pkg::CNT_W-1:0]       r_sectors_left, n_sectors_left;
    logic [atap_pkg::WIDX_W-1:0]      r_word_index, n_word_index;
    logic [atap_pkg::POLL_W-1:0]      r_polls_done, n_polls_done;

    atap_pkg::t_run_desc              run_desc;
    logic                             consume;
    logic                             wide;
    logic [atap_pkg::LBA_W-1:0]       capacity;
    logic [atap_pkg::LBA_W:0]         range_end;
    logic                             bad_count;
    logic                             out_of_range;
    logic [atap_pkg::POLL_W-1:0]      polls_inc;
    logic                             poll_expired;
    logic [atap_pkg::CNT_W-1:0]       sectors_dec;
    logic                             fin;
    logic [2:0]                       fin_code;

    // Start checks: count, then range against the selected capacity
    assign wide      = r_in.operation[1];
    assign capacity  = wide ? i_cfg.total_sectors_long
                            : {16'd0, i_cfg.total_sectors_short};
    assign range_end = {1'b0, r_in.start_address} + {33'd0, r_in.sector_total};
    assign bad_count = (r_in.sector_total == '0)
                    || (!wide && (r_in.sector_total > atap_pkg::MAX_COUNT28));
    // A nonzero count makes the end check cover the start check too
    assign out_of_range = range_end > {1'b0, capacity};

    assign polls_inc    = r_polls_done + 1'b1;
    assign poll_expired = polls_inc >= i_cfg.poll_limit;
    assign sectors_dec  = r_sectors_left - 1'b1;

    // Next state and result run for the held item
    always_comb begin
        n_phase        = r_phase;
        n_writing      = r_writing;
        n_sectors_left = r_sectors_left;
        n_word_index   = r_word_index;
        n_polls_done   = r_polls_done;
        fin            = 1'b0;
        fin_code       = atap_pkg::C_OK;

        run_desc         = '0;
        run_desc.run     = atap_pkg::RUN_NONE;
        run_desc.tail    = atap_pkg::TAIL_NONE;
        run_desc.writing = r_writing;
        run_desc.lba     = r_in.start_address;
        run_desc.count   = r_in.sector_total;
        run_desc.word    = r_in.data_word;
        run_desc.drive   = atap_pkg::DRV_BASE | {3'd0, i_cfg.slave_select, 4'd0}
                         | (wide ? 8'd0 : {4'd0, r_in.start_address[27:24]});
        case ({wide, r_in.operation[0]})
            2'b00:   run_desc.command = atap_pkg::CMD_RD28;
            2'b01:   run_desc.command = atap_pkg::CMD_WR28;
            2'b10:   run_desc.command = atap_pkg::CMD_RD48;
            default: run_desc.command = atap_pkg::CMD_WR48;
        endcase

        case (r_phase)
            atap_pkg::PH_IDLE: begin
                if (r_in.operation inside {atap_pkg::OP_READ28, atap_pkg::OP_WRITE28,
                                           atap_pkg::OP_READ48, atap_pkg::OP_WRITE48}) begin
                    if (bad_count) begin
                        fin      = 1'b1;
                        fin_code = atap_pkg::C_BADCOUNT;
                    end else if (out_of_range) begin
                        fin      = 1'b1;
                        fin_code = atap_pkg::C_RANGE;
                    end else begin
                        run_desc.run   = wide ? atap_pkg::RUN_TASK48 : atap_pkg::RUN_TASK28;
                        n_writing      = r_in.operation[0];
                        n_sectors_left = r_in.sector_total;
                        n_word_index   = '0;
                        n_polls_done   = '0;
                        n_phase        = atap_pkg::PH_DRQ;
                    end
                end
            end
            atap_pkg::PH_DRQ: begin
                if (r_in.operation == atap_pkg::OP_STATUS) begin
                    n_polls_done = polls_inc;
                    if (r_in.status_byte[atap_pkg::ST_ERR_BIT]) begin
                        fin      = 1'b1;
                        fin_code = atap_pkg::C_ERROR;
                    end else if (r_in.status_byte[atap_pkg::ST_DF_BIT]) begin
                        fin      = 1'b1;
                        fin_code = atap_pkg::C_FAULT;
                    end else if (r_in.status_byte[atap_pkg::ST_DRQ_BIT]
                                 && !r_in.status_byte[atap_pkg::ST_BSY_BIT]) begin
                        n_phase      = atap_pkg::PH_DATA;
                        n_word_index = '0;
                        n_polls_done = '0;
                    end else if (poll_expired) begin
                        fin      = 1'b1;
                        fin_code = atap_pkg::C_TIMEOUT;
                    end else begin
                        run_desc.run = atap_pkg::RUN_STATUS;
                    end
                end
            end
            atap_pkg::PH_BSY: begin
                if (r_in.operation == atap_pkg::OP_STATUS) begin
                    n_polls_done = polls_inc;
                    if (!r_in.status_byte[atap_pkg::ST_BSY_BIT]) begin
                        fin      = 1'b1;
                        fin_code = atap_pkg::C_OK;
                    end else if (poll_expired) begin
                        fin      = 1'b1;
                        fin_code = atap_pkg::C_TIMEOUT;
                    end else begin
                        run_desc.run = atap_pkg::RUN_STATUS;
                    end
                end
            end
            atap_pkg::PH_DATA: begin
                if (r_in.operation == atap_pkg::OP_DATA) begin
                    run_desc.run = atap_pkg::RUN_WORD;
                    if (r_word_index != atap_pkg::WIDX_LAST) begin
                        n_word_index = r_word_index + 1'b1;
                    end else begin
                        // End of sector: next DRQ wait, flush, or done
                        n_word_index   = '0;
                        n_sectors_left = sectors_dec;
                        n_polls_done   = '0;
                        if (sectors_dec != '0) begin
                            run_desc.tail = atap_pkg::TAIL_STATUS;
                            n_phase       = atap_pkg::PH_DRQ;
                        end else if (r_writing) begin
                            run_desc.tail = atap_pkg::TAIL_FLUSH;
                            n_phase       = atap_pkg::PH_BSY;
                        end else begin
                            run_desc.tail = atap_pkg::TAIL_DONE;
                            n_phase       = atap_pkg::PH_IDLE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        // Finish the command with a completion
        if (fin) begin
            run_desc.run   = atap_pkg::RUN_DONE;
            run_desc.code  = fin_code;
            n_phase        = atap_pkg::PH_IDLE;
            n_sectors_left = '0;
            n_word_index   = '0;
            n_polls_done   = '0;
        end
    end

    // Take the held item once its run has somewhere to go
    assign consume    = r_in_valid && ((run_desc.run == atap_pkg::RUN_NONE) || i_run_free);
    assign o_in_ready = !r_in_valid || consume;
    assign o_run_load = consume && (run_desc.run != atap_pkg::RUN_NONE);
    assign o_run      = run_desc;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_phase        <= atap_pkg::PH_IDLE;
            r_writing      <= 1'b0;
            r_sectors_left <= '0;
            r_word_index   <= '0;
            r_polls_done   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (consume) begin
                r_phase        <= n_phase;
                r_writing      <= n_writing;
                r_sectors_left <= n_sectors_left;
                r_word_index   <= n_word_index;
                r_polls_done   <= n_polls_done;
            end
        end
    end

    // Input payload
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in;
        end
    end

    a_data_has_sectors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == atap_pkg::PH_DATA) |-> (r_sectors_left != '0))
        else $error("data phase with no sectors left");

    a_idle_counters_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == atap_pkg::PH_IDLE) |-> (r_word_index == '0 && r_polls_done == '0))
        else $error("idle with live word or poll counters");

endmodule
`default_nettype wire

// ----- rtl/atap_emitter.sv -----
// Result sequencer: steps a run into the output register one result per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none
module atap_emitter (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_run_load,
    input  wire atap_pkg::t_run_desc i_run,
    output logic                     o_run_free,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output atap_pkg::t_out_item      o_out
);

    atap_pkg::t_run_desc              r_run;
    logic                             r_run_valid;
    logic [atap_pkg::RUN_IDX_W-1:0]   r_idx;
    atap_pkg::t_out_item              r_out;
    logic                             r_out_valid;

    logic                             advance;
    logic [atap_pkg::RUN_IDX_W-1:0]   last_idx;
    logic                             at_last;
    atap_pkg::t_out_item              cur;

    function automatic atap_pkg::t_out_item mk_reg(input logic [2:0] off,
                                                   input logic [15:0] val);
        atap_pkg::t_out_item r;
        r                 = '0;
        r.kind            = atap_pkg::K_REG;
        r.register_offset = off;
        r.value           = val;
        return r;
    endfunction

    function automatic atap_pkg::t_out_item mk_status();
        atap_pkg::t_out_item r;
        r                 = '0;
        r.kind            = atap_pkg::K_STATUS;
        r.register_offset = atap_pkg::REG_CMD;
        return r;
    endfunction

    function automatic atap_pkg::t_out_item mk_done(input logic [2:0] code);
        atap_pkg::t_out_item r;
        r                 = '0;
        r.kind            = atap_pkg::K_DONE;
        r.completion_code = code;
        return r;
    endfunction

    // Index of the final result of a run
    function automatic logic [atap_pkg::RUN_IDX_W-1:0] run_last(input atap_pkg::t_run run,
                                                              input atap_pkg::t_tail tail);
        logic [atap_pkg::RUN_IDX_W-1:0] n;
        n = '0;
        case (run)
            atap_pkg::RUN_TASK28: n = 4'd6;
            atap_pkg::RUN_TASK48: n = 4'd10;
            atap_pkg::RUN_WORD: begin
                case (tail)
                    atap_pkg::TAIL_STATUS: n = 4'd1;
                    atap_pkg::TAIL_FLUSH:  n = 4'd2;
                    atap_pkg::TAIL_DONE:   n = 4'd1;
                    default:               n = 4'd0;
                endcase
            end
            default: n = '0;
        endcase
        return n;
    endfunction

    assign advance    = !r_out_valid || i_out_ready;
    assign last_idx   = run_last(r_run.run, r_run.tail);
    assign at_last    = r_idx == last_idx;
    assign o_run_free = !r_run_valid || (advance && at_last);

    // Build the result at the current run position
    always_comb begin
        cur = '0;
        case (r_run.run)
            atap_pkg::RUN_DONE:   cur = mk_done(r_run.code);
            atap_pkg::RUN_STATUS: cur = mk_status();
            atap_pkg::RUN_TASK28: begin
                case (r_idx)
                    4'd0:    cur = mk_reg(atap_pkg::REG_DRIVE, {8'd0, r_run.drive});
                    4'd1:    cur = mk_reg(atap_pkg::REG_COUNT, {8'd0, r_run.count[7:0]});
                    4'd2:    cur = mk_reg(atap_pkg::REG_LBA0, {8'd0, r_run.lba[7:0]});
                    4'd3:    cur = mk_reg(atap_pkg::REG_LBA1, {8'd0, r_run.lba[15:8]});
                    4'd4:    cur = mk_reg(atap_pkg::REG_LBA2, {8'd0, r_run.lba[23:16]});
                    4'd5:    cur = mk_reg(atap_pkg::REG_CMD, {8'd0, r_run.command});
                    default: cur = mk_status();
                endcase
            end
            atap_pkg::RUN_TASK48: begin
                // High-order bytes first, then the low-order ones
                case (r_idx)
                    4'd0:    cur = mk_reg(atap_pkg::REG_DRIVE, {8'd0, r_run.drive});
                    4'd1:    cur = mk_reg(atap_pkg::REG_COUNT, {8'd0, r_run.count[15:8]});
                    4'd2:    cur = mk_reg(atap_pkg::REG_LBA0, {8'd0, r_run.lba[31:24]});
                    4'd3:    cur = mk_reg(atap_pkg::REG_LBA1, {8'd0, r_run.lba[39:32]});
                    4'd4:    cur = mk_reg(atap_pkg::REG_LBA2, {8'd0, r_run.lba[47:40]});
                    4'd5:    cur = mk_reg(atap_pkg::REG_COUNT, {8'd0, r_run.count[7:0]});
                    4'd6:    cur = mk_reg(atap_pkg::REG_LBA0, {8'd0, r_run.lba[7:0]});
                    4'd7:    cur = mk_reg(atap_pkg::REG_LBA1, {8'd0, r_run.lba[15:8]});
                    4'd8:    cur = mk_reg(atap_pkg::REG_LBA2, {8'd0, r_run.lba[23:16]});
                    4'd9:    cur = mk_reg(atap_pkg::REG_CMD, {8'd0, r_run.command});
                    default: cur = mk_status();
                endcase
            end
            atap_pkg::RUN_WORD: begin
                if (r_idx == '0) begin
                    if (r_run.writing) begin
                        cur = mk_reg(atap_pkg::REG_DATA, r_run.word);
                    end else begin
                        cur       = '0;
                        cur.kind  = atap_pkg::K_WORD;
                        cur.value = r_run.word;
                    end
                end else begin
                    case (r_run.tail)
                        atap_pkg::TAIL_FLUSH: begin
                            cur = (r_idx == 4'd1)
                                ? mk_reg(atap_pkg::REG_CMD, {8'd0, atap_pkg::CMD_FLUSH})
                                : mk_status();
                        end
                        atap_pkg::TAIL_DONE: cur = mk_done(atap_pkg::C_OK);
                        default:             cur = mk_status();
                    endcase
                end
            end
            default: cur = '0;
        endcase
        cur.last_of_run = at_last;
    end

    // Advance the run and load the next one behind its last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= r_run_valid;
            end
            if (advance && r_run_valid && !at_last) begin
                r_idx <= r_idx + 1'b1;
            end
            if (o_run_free) begin
                r_run_valid <= i_run_load;
                r_idx       <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= cur;
        end
        if (o_run_free && i_run_load) begin
            r_run <= i_run;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_valid |-> (r_idx <= last_idx))
        else $error("run index past its final result");

    a_run_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_of_run) |-> r_run_valid)
        else $error("result run cut short");

endmodule
`default_nettype wire

// ----- rtl/ata_pio_sector_transfer_sequencer_top.sv -----
// Top level of the ATA PIO sector transfer sequencer.
//
// Input channel (i_in_valid / o_in_ready / i_in) takes start, status and data
// items; output channel (o_out_valid / i_out_ready / o_out) gives register
// writes, status read requests, host words and completions. Both use
// valid/ready; an item moves at a clock edge with both high.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data; the user must write
// only while the block is idle, as the block itself does not enforce it.
// The first result of an item passes from the input register through the run
// register into the output register.
// Throughput: one item per cycle, unless the receiver stalls, whenever each item
// causes one result, as for data words inside a sector. The output register shows
// one result per cycle unless stalled, so a start or an end-of-sector word holds
// the input until its run is out; meanwhile one more item waits in the input
// register. Items that cause no result are dropped even while a run is busy.
// Reset (i_rst_n low, synchronous) empties the input, run and output
// registers, returns the engine to idle and loads the register defaults
// (poll limit 100000).
// A stalled receiver holds the current result; the run and the input register
// fill, then o_in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module ata_pio_sector_transfer_sequencer_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [atap_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [atap_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire atap_pkg::t_in_item                 i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output atap_pkg::t_out_item                     o_out
);

    atap_pkg::t_cfg       cfg;
    atap_pkg::t_run_desc  run;
    logic                 run_load;
    logic                 run_free;

    atap_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    atap_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_run_free (run_free),
        .o_run_load (run_load),
        .o_run      (run)
    );

    atap_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_load  (run_load),
        .i_run       (run),
        .o_run_free  (run_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
